[sv/mee_pkg.sv]
package mee_pkg;

  // APB register map: one 64-bit register per 8-byte slot
  localparam int APB_DW = 64;
  localparam int ADDR_W = 4;
  localparam logic REG_MODULUS = 1'b0;

  localparam logic [63:0] RESET_MODULUS = 64'd1000000007;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

endpackage

[sv/mee_cfg.sv]
module mee_cfg #(
  parameter int MW = 62
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mee_pkg::ADDR_W-1:0]  paddr,
  input  logic [mee_pkg::APB_DW-1:0]  pwdata,
  output logic [mee_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output logic [MW-1:0]               modulus
);
  import mee_pkg::*;

  logic reg_idx;
  logic wr_en;

  assign reg_idx = paddr[ADDR_W-1];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= RESET_MODULUS[MW-1:0];
    end else if (wr_en && reg_idx == REG_MODULUS) begin
      modulus <= pwdata[MW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx == REG_MODULUS) begin
      prdata[MW-1:0] = modulus;
    end
  end

endmodule

[sv/mee_modmul.sv]
module mee_modmul #(
  parameter int MW = 62
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MW-1:0]      x_in,
  input  logic [MW-1:0]      y1_in,
  input  logic [MW-1:0]      y2_in,
  input  logic [MW-1:0]      modulus,
  output mee_pkg::mul_stat_t stat,
  output logic [MW-1:0]      prod1,
  output logic [MW-1:0]      prod2
);
  import mee_pkg::*;

  localparam int CW = $clog2(MW);
  localparam logic [CW-1:0] LAST = CW'(MW - 1);

  logic          busy;
  logic          done;
  logic [CW-1:0] cnt;
  logic [MW-1:0] x;
  logic [MW-1:0] y1;
  logic [MW-1:0] y2;
  logic [MW-1:0] acc1;
  logic [MW-1:0] acc2;
  logic [MW-1:0] x_next;
  logic [MW-1:0] acc1_next;
  logic [MW-1:0] acc2_next;

  function automatic logic [MW-1:0] add_mod(input logic [MW-1:0] a,
                                            input logic [MW-1:0] b,
                                            input logic [MW-1:0] m);
    logic [MW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MW-1:0];
  endfunction

  // Both products share the multiplicand x: acc1 = x*y1, acc2 = x*y2 (mod m)
  always_comb begin
    x_next    = add_mod(x, x, modulus);
    acc1_next = y1[0] ? add_mod(acc1, x, modulus) : acc1;
    acc2_next = y2[0] ? add_mod(acc2, x, modulus) : acc2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        x    <= x_in;
        y1   <= y1_in;
        y2   <= y2_in;
        acc1 <= '0;
        acc2 <= '0;
      end else if (busy) begin
        x    <= x_next;
        acc1 <= acc1_next;
        acc2 <= acc2_next;
        y1   <= {1'b0, y1[MW-1:1]};
        y2   <= {1'b0, y2[MW-1:1]};
        cnt  <= cnt + 1'b1;
        if (cnt == LAST) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign prod1     = acc1;
  assign prod2     = acc2;

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("product done without a running multiply");

  a_operands_reduced: assert property (@(posedge clk) disable iff (rst)
    (busy && !start) |-> (acc1 < modulus && acc2 < modulus && x < modulus))
    else $error("multiply operand left the residue range");

endmodule

[sv/modular_exponentiation_unit.sv]
// Computes base^exponent mod modulus by right-to-left square-and-multiply.
// The base is first reduced by restoring division; each exponent bit then takes one
// shared-multiplicand multiply; a zero exponent skips both and gives 1.
// The bit-serial modular multiplier (one multiplier bit per cycle) sets the rate;
// one item is in work at a time, and the next may enter while a result waits.
// Synchronous reset clears control and loads the modulus register with 1000000007.
module modular_exponentiation_unit #(
  parameter int DATA_WIDTH = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [DATA_WIDTH-2:0]       base_value,
  input  logic [DATA_WIDTH-2:0]       exponent_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [DATA_WIDTH-3:0]       power_result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mee_pkg::ADDR_W-1:0]  paddr,
  input  logic [mee_pkg::APB_DW-1:0]  pwdata,
  output logic [mee_pkg::APB_DW-1:0]  prdata,
  output logic                        pready
);
  import mee_pkg::*;

  localparam int IW  = DATA_WIDTH - 1;
  localparam int MW  = DATA_WIDTH - 2;
  localparam int RCW = $clog2(IW);
  localparam logic [RCW-1:0] RLAST = RCW'(IW - 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REDUCE = 3'd1;
  localparam logic [2:0] S_EXP    = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0]     state;
  logic [IW-1:0]  e_q;
  logic [IW-1:0]  bsh;
  logic [MW-1:0]  b_q;
  logic [MW-1:0]  r_q;
  logic [RCW-1:0] rcnt;
  logic [MW-1:0]  modulus;
  logic [MW:0]    rem_sh;
  logic [MW:0]    rem_red;
  logic           in_acc;
  logic           out_free;
  logic           out_load;
  logic           mul_start;
  mul_stat_t      mul_stat;
  logic [MW-1:0]  prod1;
  logic [MW-1:0]  prod2;

  mee_cfg #(.MW(MW)) u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .modulus (modulus)
  );

  mee_modmul #(.MW(MW)) u_modmul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .x_in    (b_q),
    .y1_in   (r_q),
    .y2_in   (b_q),
    .modulus (modulus),
    .stat    (mul_stat),
    .prod1   (prod1),
    .prod2   (prod2)
  );

  assign in_stall  = (state != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = (state == S_FINISH) && out_free;
  assign mul_start = (state == S_EXP) && (e_q != '0);

  // One restoring-division step per cycle: shift in the next base bit
  assign rem_sh  = {b_q, bsh[IW-1]};
  assign rem_red = (rem_sh >= {1'b0, modulus}) ? rem_sh - {1'b0, modulus} : rem_sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rcnt      <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            e_q  <= exponent_value;
            bsh  <= base_value;
            b_q  <= '0;
            rcnt <= '0;
            if (exponent_value == '0) begin
              r_q   <= MW'(1);
              state <= S_FINISH;
            end else if (modulus == '0) begin
              r_q   <= '0;
              state <= S_FINISH;
            end else begin
              state <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          b_q  <= rem_red[MW-1:0];
          bsh  <= {bsh[IW-2:0], 1'b0};
          rcnt <= rcnt + 1'b1;
          if (rcnt == RLAST) begin
            r_q   <= (modulus == MW'(1)) ? '0 : MW'(1);
            state <= S_EXP;
          end
        end
        S_EXP: begin
          state <= (e_q == '0) ? S_FINISH : S_WAIT;
        end
        S_WAIT: begin
          if (mul_stat.done) begin
            if (e_q[0]) begin
              r_q <= prod1;
            end
            b_q   <= prod2;
            e_q   <= {1'b0, e_q[IW-1:1]};
            state <= S_EXP;
          end
        end
        S_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            power_result <= r_q;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state != S_IDLE))
    else $error("accepted item did not start work");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_FINISH))
    else $error("result shown without a finished item");

  a_residues_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXP) |-> (r_q < modulus && b_q < modulus))
    else $error("exponentiation state left the residue range");

  a_mul_idle_on_start: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mul_stat.busy)
    else $error("multiply started while busy");

endmodule
